FILE: design/ccle_pkg.sv
// shared types and codes for the cheat code line executor
package ccle_pkg;

	localparam int ADDR_W = 28;
	localparam int WADDR_W = ADDR_W - 2;

	localparam logic [1:0] FUNC_LINE  = 2'd0;
	localparam logic [1:0] FUNC_STORE = 2'd1;
	localparam logic [1:0] FUNC_LOAD  = 2'd2;

	localparam logic [3:0] CT_OR   = 4'h2;
	localparam logic [3:0] CT_BSET = 4'h3;
	localparam logic [3:0] CT_AND  = 4'h6;
	localparam logic [3:0] CT_EQ   = 4'h7;
	localparam logic [3:0] CT_HSET = 4'h8;
	localparam logic [3:0] CT_NE   = 4'hA;
	localparam logic [3:0] CT_GT   = 4'hB;
	localparam logic [3:0] CT_LT   = 4'hC;
	localparam logic [3:0] CT_KEYS = 4'hD;
	localparam logic [3:0] CT_ADD  = 4'hE;
	localparam logic [3:0] CT_MASK = 4'hF;

	localparam logic [1:0] BYTE_HI = 2'd3;

	localparam logic [ADDR_W-1:0] KEY_TEST_ADDR = 28'h0000020;

	typedef struct packed {
		logic [1:0]        func;
		logic [3:0]        code_type;
		logic [ADDR_W-1:0] address;
		logic [15:0]       operand;
		logic              long_operand;
		logic              cheat_start;
		logic [31:0]       host_data;
		logic [15:0]       keypad;
	} req_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        execute_next;
	} res_item_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic exe;
		logic wr2;
	} ccle_cmd_t;

	typedef struct packed {
		logic idx_done;
		logic need_wr2;
	} ccle_status_t;

endpackage

FILE: design/cheat_code_line_executor.sv
// top level of the cheat code line executor
// Takes one request at a time on req (valid/stall): a cheat code line to run against
// the local word memory, a host word store or a host word load. Every request gives
// exactly one result on res (valid/stall): the loaded word (zero otherwise) and the
// flag that says whether the next line runs.
// When MEM_WORDS is a power of two a request passes through these steps: capture it and
// reduce the address, the synchronous memory read, then modify, write back and load
// the result register. A halfword at byte offset 3 that is written adds a write step
// for the following word on the single write port. For other depths the word index
// is reduced by a reciprocal multiplication and a correcting subtract before the read.
// The next request is taken while a finished result still waits in the result register;
// if the receiver keeps stalling, the following result holds in the execute step until
// the register frees.
// Reset clears the control state and sets the run-next flag; memory contents are
// undefined until written.
module cheat_code_line_executor import ccle_pkg::*; #(
	parameter int MEM_WORDS = 16384
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res
);

	ccle_cmd_t    cmd;
	ccle_status_t status;

	ccle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ccle_dp #(
		.MEM_WORDS(MEM_WORDS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.status(status),
		.res   (res)
	);

endmodule

FILE: design/ccle_wmod.sv
// word index reduction modulo the memory depth
module ccle_wmod import ccle_pkg::*; #(
	parameter int MEM_WORDS = 16384
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [WADDR_W-1:0]           value,
	output logic                         done,
	output logic [$clog2(MEM_WORDS)-1:0] index
);

	localparam int IW = $clog2(MEM_WORDS);

	generate
		if ((1 << IW) == MEM_WORDS) begin : g_pow2
			logic [IW-1:0] rem_q;

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= value[IW-1:0];
				end
			end

			assign done  = 1'b1;
			assign index = rem_q;
		end else begin : g_recip
			localparam int DW = WADDR_W + 1;
			localparam int QW = WADDR_W + 1 - IW;
			localparam int SH = WADDR_W + IW;
			localparam int PW = WADDR_W + DW;
			localparam logic [DW-1:0] RECIP = DW'((64'd1 << SH) / 64'(MEM_WORDS));
			localparam logic [DW-1:0] DEPTH = DW'(MEM_WORDS);

			localparam logic [1:0] PH_DONE = 2'd0;
			localparam logic [1:0] PH_QUO  = 2'd1;
			localparam logic [1:0] PH_REM  = 2'd2;
			localparam logic [1:0] PH_FIX  = 2'd3;

			logic [WADDR_W-1:0] val_q;
			logic [QW-1:0]      quo_q;
			logic [DW-1:0]      rem_q;
			logic [1:0]         ph_q;
			logic [PW-1:0]      prod;
			logic [DW-1:0]      back;

			// quotient estimate is exact or one low, fixed by one subtract
			assign prod = PW'(val_q) * PW'(RECIP);
			assign back = DW'(quo_q) * DEPTH;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ph_q <= PH_DONE;
				end else if (start) begin
					ph_q <= PH_QUO;
				end else begin
					unique case (ph_q)
						PH_QUO:  ph_q <= PH_REM;
						PH_REM:  ph_q <= PH_FIX;
						default: ph_q <= PH_DONE;
					endcase
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					val_q <= value;
				end
				if (ph_q == PH_QUO) begin
					quo_q <= prod[PW-1:SH];
				end
				if (ph_q == PH_REM) begin
					rem_q <= {1'b0, val_q} - back;
				end else if (ph_q == PH_FIX && rem_q >= DEPTH) begin
					rem_q <= rem_q - DEPTH;
				end
			end

			assign done  = (ph_q == PH_DONE);
			assign index = rem_q[IW-1:0];
		end
	endgenerate

endmodule

FILE: design/ccle_ctrl.sv
// control state machine for the cheat code line executor
module ccle_ctrl import ccle_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	output logic         res_valid,
	input  logic         res_stall,
	input  ccle_status_t status,
	output ccle_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_EXE  = 2'd2;
	localparam logic [1:0] ST_WR2  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       res_valid_q;
	logic       res_free;

	assign res_free  = !res_valid_q || !res_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_RD;
				end
			end
			ST_RD: begin
				if (status.idx_done) begin
					cmd.rd     = 1'b1;
					state_next = ST_EXE;
				end
			end
			ST_EXE: begin
				if (res_free) begin
					cmd.exe    = 1'b1;
					state_next = status.need_wr2 ? ST_WR2 : ST_IDLE;
				end
			end
			ST_WR2: begin
				cmd.wr2    = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.exe) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/ccle_dp.sv
// datapath: request register, word memory, line execution and result register
module ccle_dp import ccle_pkg::*; #(
	parameter int MEM_WORDS = 16384
) (
	input  logic         clk,
	input  logic         arst_n,
	input  req_item_t    req,
	input  ccle_cmd_t    cmd,
	output ccle_status_t status,
	output res_item_t    res
);

	localparam int IW = $clog2(MEM_WORDS);
	localparam logic [IW:0] DEPTH = (IW + 1)'(MEM_WORDS);

	req_item_t   item_q;
	res_item_t   res_q;
	logic        flag_q;
	logic [31:0] mem [MEM_WORDS];
	logic [31:0] w0_q;
	logic [31:0] w1_q;

	logic [IW-1:0] idx;
	logic [IW:0]   idx_inc;
	logic [IW-1:0] idx1;
	logic          idx_done;

	logic [1:0]  boff;
	logic [15:0] cur16;
	logic [15:0] new16;
	logic        is_line;
	logic        flag_start;
	logic        run;
	logic        is_test;
	logic        test_res;
	logic        wr_hw;
	logic        wr_b;
	logic        host_wr;
	logic        flag_next;
	logic [31:0] w0_new;
	logic [31:0] w1_new;
	logic        we;
	logic [IW-1:0] waddr;
	logic [31:0] wdata;

	ccle_wmod #(
		.MEM_WORDS(MEM_WORDS)
	) u_wmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.load),
		.value (req.address[ADDR_W-1:2]),
		.done  (idx_done),
		.index (idx)
	);

	assign idx_inc = {1'b0, idx} + 1'b1;
	assign idx1    = (idx_inc == DEPTH) ? '0 : idx_inc[IW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
	end

	assign boff = item_q.address[1:0];

	always_comb begin
		case (boff)
			2'd0:    cur16 = w0_q[15:0];
			2'd1:    cur16 = w0_q[23:8];
			2'd2:    cur16 = w0_q[31:16];
			default: cur16 = {w1_q[7:0], w0_q[31:24]};
		endcase
	end

	assign is_line    = (item_q.func == FUNC_LINE);
	assign host_wr    = (item_q.func == FUNC_STORE);
	assign flag_start = item_q.cheat_start || flag_q;
	assign run        = is_line && !item_q.long_operand && flag_start;

	always_comb begin
		new16    = cur16;
		wr_hw    = 1'b0;
		wr_b     = 1'b0;
		is_test  = 1'b0;
		test_res = 1'b0;
		unique case (item_q.code_type) inside
			CT_OR: begin
				new16 = cur16 | item_q.operand;
				wr_hw = 1'b1;
			end
			CT_AND: begin
				new16 = cur16 & item_q.operand;
				wr_hw = 1'b1;
			end
			CT_ADD: begin
				new16 = cur16 + item_q.operand;
				wr_hw = 1'b1;
			end
			CT_HSET: begin
				new16 = item_q.operand;
				wr_hw = 1'b1;
			end
			CT_BSET: begin
				wr_b = 1'b1;
			end
			CT_EQ: begin
				is_test  = 1'b1;
				test_res = (cur16 == item_q.operand);
			end
			CT_NE: begin
				is_test  = 1'b1;
				test_res = (cur16 != item_q.operand);
			end
			CT_GT: begin
				is_test  = 1'b1;
				test_res = (cur16 > item_q.operand);
			end
			CT_LT: begin
				is_test  = 1'b1;
				test_res = (cur16 < item_q.operand);
			end
			CT_MASK: begin
				is_test  = 1'b1;
				test_res = ((cur16 & item_q.operand) != '0);
			end
			CT_KEYS: begin
				is_test  = (item_q.address == KEY_TEST_ADDR);
				test_res = ((item_q.keypad & item_q.operand) == '0);
			end
			default: begin
				new16 = cur16;
			end
		endcase
	end

	always_comb begin
		if (!is_line) begin
			flag_next = flag_q;
		end else if (item_q.long_operand) begin
			flag_next = flag_start;
		end else if (run && is_test) begin
			flag_next = test_res;
		end else begin
			flag_next = 1'b1;
		end
	end

	always_comb begin
		w0_new = w0_q;
		if (host_wr) begin
			w0_new = item_q.host_data;
		end else if (run && wr_b) begin
			case (boff)
				2'd0:    w0_new[7:0]   = item_q.operand[7:0];
				2'd1:    w0_new[15:8]  = item_q.operand[7:0];
				2'd2:    w0_new[23:16] = item_q.operand[7:0];
				default: w0_new[31:24] = item_q.operand[7:0];
			endcase
		end else if (run && wr_hw) begin
			case (boff)
				2'd0:    w0_new[15:0]  = new16;
				2'd1:    w0_new[23:8]  = new16;
				2'd2:    w0_new[31:16] = new16;
				default: w0_new[31:24] = new16[7:0];
			endcase
		end
	end

	assign w1_new = {w1_q[31:8], new16[15:8]};

	assign status.idx_done = idx_done;
	assign status.need_wr2 = run && wr_hw && (boff == BYTE_HI);

	assign we    = cmd.wr2 || (cmd.exe && (host_wr || (run && (wr_hw || wr_b))));
	assign waddr = cmd.wr2 ? idx1 : idx;
	assign wdata = cmd.wr2 ? w1_new : w0_new;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			w0_q <= mem[idx];
			w1_q <= mem[idx1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b1;
		end else if (cmd.exe) begin
			flag_q <= flag_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exe) begin
			res_q.read_data    <= (item_q.func == FUNC_LOAD) ? w0_q : '0;
			res_q.execute_next <= flag_next;
		end
	end

	assign res = res_q;

endmodule
